[rtl/lept_pkg.sv]
// Shared types, register codes and constants of the latency envelope profile tuner.
package lept_pkg;

  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_LATENCY = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENVELOPE_FRACTION = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_P99_CEILING = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_THREAD_FLOOR = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_THREAD_CEILING = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_BATCH_FLOOR = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_BATCH_CEILING = 3'd6;

  localparam logic [23:0] TARGET_LATENCY_RESET = 24'd1000;
  localparam logic [15:0] ENVELOPE_FRACTION_RESET = 16'd3277;
  localparam logic [23:0] P99_CEILING_RESET = 24'd2000;
  localparam logic [7:0] THREAD_FLOOR_RESET = 8'd1;
  localparam logic [7:0] THREAD_CEILING_RESET = 8'd8;
  localparam logic [11:0] BATCH_FLOOR_RESET = 12'd1;
  localparam logic [11:0] BATCH_CEILING_RESET = 12'd64;

  localparam int unsigned TILE_MIN_DEFAULT = 16;
  localparam int unsigned TILE_MAX_DEFAULT = 256;
  localparam int unsigned PACE_MAX_NS_DEFAULT = 2000000;

  localparam int unsigned FLAG_THERMAL = 4;
  localparam logic [15:0] MIN_SAMPLES = 16'd8;
  localparam logic [28:0] FAST_MEAN_SCALE = 29'd20;
  localparam logic [28:0] FAST_TARGET_SCALE = 29'd19;
  localparam longint unsigned PACE_SLOPE = 800;
  localparam longint unsigned PACE_P99_NS = 150000;
  localparam logic [31:0] DIV10_MUL = 32'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  typedef struct packed {
    logic [23:0] mean_latency;
    logic [23:0] p99_latency;
    logic [15:0] sample_count;
    logic [4:0] instability_flags;
  } stats_t;

  typedef struct packed {
    logic [7:0] thread_count_out;
    logic [11:0] batch_size_out;
    logic [11:0] tile_size_out;
    logic env_ok;
    logic [20:0] pace_increment_ns;
  } profile_t;

  typedef struct packed {
    logic [23:0] target_latency;
    logic [15:0] envelope_fraction;
    logic [23:0] p99_ceiling;
    logic [7:0] thread_floor;
    logic [7:0] thread_ceiling;
    logic [11:0] batch_floor;
    logic [11:0] batch_ceiling;
  } cfg_t;

  typedef struct packed {
    logic unstable;
    logic thermal;
    logic fast;
    logic above_hi;
    logic p99_bad;
    logic env_ok;
    logic [20:0] pace;
  } env_t;

endpackage

[rtl/lept_cfg.sv]
// Configuration registers and the profile reload request of the tuner.
module lept_cfg (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [lept_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lept_pkg::CFG_DATA_W-1:0] cfg_data,
  output lept_pkg::cfg_t cfg,
  output logic reload
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_latency <= lept_pkg::TARGET_LATENCY_RESET;
      cfg.envelope_fraction <= lept_pkg::ENVELOPE_FRACTION_RESET;
      cfg.p99_ceiling <= lept_pkg::P99_CEILING_RESET;
      cfg.thread_floor <= lept_pkg::THREAD_FLOOR_RESET;
      cfg.thread_ceiling <= lept_pkg::THREAD_CEILING_RESET;
      cfg.batch_floor <= lept_pkg::BATCH_FLOOR_RESET;
      cfg.batch_ceiling <= lept_pkg::BATCH_CEILING_RESET;
      reload <= 1'b0;
    end else begin
      reload <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          lept_pkg::CFG_TARGET_LATENCY: cfg.target_latency <= cfg_data;
          lept_pkg::CFG_ENVELOPE_FRACTION: cfg.envelope_fraction <= cfg_data[15:0];
          lept_pkg::CFG_P99_CEILING: cfg.p99_ceiling <= cfg_data;
          lept_pkg::CFG_THREAD_FLOOR: begin
            cfg.thread_floor <= cfg_data[7:0];
            reload <= 1'b1;
          end
          lept_pkg::CFG_THREAD_CEILING: begin
            cfg.thread_ceiling <= cfg_data[7:0];
            reload <= 1'b1;
          end
          lept_pkg::CFG_BATCH_FLOOR: begin
            cfg.batch_floor <= cfg_data[11:0];
            reload <= 1'b1;
          end
          lept_pkg::CFG_BATCH_CEILING: begin
            cfg.batch_ceiling <= cfg_data[11:0];
            reload <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

[rtl/lept_env.sv]
// Envelope pipeline: input register, bound products, compares and pacing increment.
module lept_env #(
  parameter int unsigned PACE_MAX_NS = lept_pkg::PACE_MAX_NS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic stats_valid,
  input  lept_pkg::stats_t stats,
  output logic stats_stall,
  input  lept_pkg::cfg_t cfg,
  output logic env_valid,
  output lept_pkg::env_t env,
  input  logic env_ready
);

  localparam longint unsigned PACE_SAT_EXCESS =
    ((longint'(PACE_MAX_NS) + 1) * 65536 + lept_pkg::PACE_SLOPE - 1) / lept_pkg::PACE_SLOPE;
  localparam int unsigned EXC_W = $clog2(PACE_SAT_EXCESS);
  localparam int unsigned PROD_W = EXC_W + 10;
  localparam int unsigned PACE_W = $clog2(longint'(PACE_MAX_NS) + 1);

  logic s1_valid;
  lept_pkg::stats_t s1;
  logic s2_valid;
  logic [23:0] s2_mean;
  logic [40:0] s2_lo_q;
  logic [40:0] s2_hi_q;
  logic s2_p99_bad;
  logic s2_fast;
  logic [4:0] s2_flags;
  logic s3_valid;
  logic s3_above_hi;
  logic s3_below_lo;
  logic s3_p99_bad;
  logic s3_fast;
  logic [4:0] s3_flags;
  logic s3_excess_sat;
  logic [EXC_W-1:0] s3_excess;

  logic s1_ready;
  logic s2_ready;
  logic s3_ready;
  logic s4_ready;
  logic [16:0] lo_span;
  logic [16:0] hi_span;
  logic [40:0] mean_q;
  logic [40:0] excess;
  logic [PROD_W-1:0] pace_prod;
  logic [PACE_W-1:0] pace_base;
  logic [PACE_W:0] pace_sum;
  logic [PACE_W-1:0] pace_final;
  lept_pkg::env_t env_next;

  assign s4_ready = !env_valid || env_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign stats_stall = !s1_ready;

  assign lo_span = 17'd65536 - {1'b0, cfg.envelope_fraction};
  assign hi_span = 17'd65536 + {1'b0, cfg.envelope_fraction};
  assign mean_q = {1'b0, s2_mean, 16'b0};
  assign excess = mean_q - s2_hi_q;

  always_comb begin
    pace_prod = PROD_W'(s3_excess) * PROD_W'(lept_pkg::PACE_SLOPE);
    if (!s3_above_hi) begin
      pace_base = '0;
    end else if (s3_excess_sat) begin
      pace_base = PACE_W'(PACE_MAX_NS);
    end else begin
      pace_base = PACE_W'(pace_prod >> 16);
    end
    pace_sum = (PACE_W+1)'(pace_base) + (PACE_W+1)'(lept_pkg::PACE_P99_NS);
    if (!s3_p99_bad) begin
      pace_final = pace_base;
    end else if (pace_sum > (PACE_W+1)'(PACE_MAX_NS)) begin
      pace_final = PACE_W'(PACE_MAX_NS);
    end else begin
      pace_final = PACE_W'(pace_sum);
    end
    env_next.unstable = s3_flags != 5'd0;
    env_next.thermal = s3_flags[lept_pkg::FLAG_THERMAL];
    env_next.fast = s3_fast;
    env_next.above_hi = s3_above_hi;
    env_next.p99_bad = s3_p99_bad;
    env_next.env_ok = !s3_above_hi && !s3_below_lo && !s3_p99_bad;
    env_next.pace = 21'(pace_final);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      env_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= stats_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (s4_ready) begin
        env_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1 <= stats;
    end
    if (s2_ready) begin
      s2_mean <= s1.mean_latency;
      s2_lo_q <= {17'b0, cfg.target_latency} * {24'b0, lo_span};
      s2_hi_q <= {17'b0, cfg.target_latency} * {24'b0, hi_span};
      s2_p99_bad <= (s1.p99_latency > cfg.p99_ceiling) &&
                    (s1.sample_count >= lept_pkg::MIN_SAMPLES);
      s2_fast <= (29'(s1.mean_latency) * lept_pkg::FAST_MEAN_SCALE) <
                 (29'(cfg.target_latency) * lept_pkg::FAST_TARGET_SCALE);
      s2_flags <= s1.instability_flags;
    end
    if (s3_ready) begin
      s3_above_hi <= mean_q > s2_hi_q;
      s3_below_lo <= mean_q < s2_lo_q;
      s3_p99_bad <= s2_p99_bad;
      s3_fast <= s2_fast;
      s3_flags <= s2_flags;
      s3_excess_sat <= excess >= 41'(PACE_SAT_EXCESS);
      s3_excess <= excess[EXC_W-1:0];
    end
    if (s4_ready) begin
      env <= env_next;
    end
  end

endmodule

[rtl/lept_prof.sv]
// Profile state (threads, batch, tile) and the result register.
module lept_prof #(
  parameter int unsigned TILE_MIN = lept_pkg::TILE_MIN_DEFAULT,
  parameter int unsigned TILE_MAX = lept_pkg::TILE_MAX_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic env_valid,
  input  lept_pkg::env_t env,
  output logic env_ready,
  input  lept_pkg::cfg_t cfg,
  input  logic reload,
  output logic profile_valid,
  output lept_pkg::profile_t profile,
  input  logic profile_stall
);

  localparam logic [11:0] TILE_LO = 12'(TILE_MIN);
  localparam logic [11:0] TILE_HI = 12'(TILE_MAX);
  localparam logic [11:0] TILE_MID = 12'((TILE_MIN + TILE_MAX) / 2);

  logic [7:0] thread_count;
  logic [11:0] batch_len;
  logic [11:0] tile_len;

  logic [7:0] thread_count_next;
  logic [11:0] batch_len_next;
  logic [11:0] tile_len_next;
  logic [7:0] thread_a;
  logic [7:0] thread_b;
  logic [13:0] batch_x3;
  logic [11:0] batch_shrink;
  logic [15:0] batch_x11;
  logic [31:0] batch_div;
  logic [12:0] batch_grow;
  logic [11:0] batch_a;
  logic [13:0] tile_x3;
  logic [11:0] tile_shrink;
  logic advance;

  assign env_ready = !profile_valid || !profile_stall;
  assign advance = env_valid && env_ready;

  always_comb begin
    thread_a = thread_count;
    if (env.unstable && thread_count > cfg.thread_floor) begin
      thread_a = thread_count - 8'd1;
    end else if (!env.unstable && env.fast && thread_count < cfg.thread_ceiling) begin
      thread_a = thread_count + 8'd1;
    end
    thread_b = env.above_hi ? cfg.thread_floor : thread_a;
    thread_count_next = thread_b;
    if (env.p99_bad && thread_b > cfg.thread_floor) begin
      thread_count_next = thread_b - 8'd1;
    end

    batch_x3 = 14'(batch_len) * 14'd3;
    batch_shrink = batch_x3[13:2];
    if (batch_shrink < cfg.batch_floor) begin
      batch_shrink = cfg.batch_floor;
    end
    batch_x11 = 16'(batch_len) * 16'd11;
    batch_div = 32'(batch_x11) * lept_pkg::DIV10_MUL;
    batch_grow = 13'(batch_div >> lept_pkg::DIV10_SHIFT) + 13'd1;
    if (batch_grow > 13'(cfg.batch_ceiling)) begin
      batch_grow = 13'(cfg.batch_ceiling);
    end
    batch_a = batch_len;
    if (env.unstable && batch_len > cfg.batch_floor) begin
      batch_a = batch_shrink;
    end else if (!env.unstable && env.fast && batch_len < cfg.batch_ceiling) begin
      batch_a = batch_grow[11:0];
    end
    batch_len_next = env.above_hi ? cfg.batch_floor : batch_a;

    tile_x3 = 14'(tile_len) * 14'd3;
    tile_shrink = tile_x3[13:2];
    if (tile_shrink < TILE_LO) begin
      tile_shrink = TILE_LO;
    end
    tile_len_next = tile_len;
    if (env.thermal && tile_len > TILE_LO) begin
      tile_len_next = tile_shrink;
    end else if (!env.unstable && tile_len < TILE_HI) begin
      tile_len_next = tile_len + 12'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thread_count <= lept_pkg::THREAD_CEILING_RESET;
      batch_len <= lept_pkg::BATCH_CEILING_RESET;
      tile_len <= TILE_MID;
      profile_valid <= 1'b0;
    end else begin
      if (advance) begin
        thread_count <= thread_count_next;
        batch_len <= batch_len_next;
        tile_len <= tile_len_next;
      end else if (reload) begin
        thread_count <= cfg.thread_ceiling;
        batch_len <= cfg.batch_ceiling;
        tile_len <= TILE_MID;
      end
      if (env_ready) begin
        profile_valid <= env_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      profile.thread_count_out <= thread_count_next;
      profile.batch_size_out <= batch_len_next;
      profile.tile_size_out <= tile_len_next;
      profile.env_ok <= env.env_ok;
      profile.pace_increment_ns <= env.pace;
    end
  end

endmodule

[rtl/latency_envelope_profile_tuner.sv]
// Top level of the latency envelope profile tuner.
//
// The stats channel (stats_valid, stats_stall, stats) takes one word of
// windowed latency statistics and instability flags. For each word the block
// updates its thread, batch and tile profile and sends one word on the
// profile channel (profile_valid, profile_stall, profile) with the new
// profile, the envelope verdict and a pacing increment.
// A word passes through an input register, a register after the bound
// products, one after the envelope compares, one after the pacing
// increment, and the result register, which also updates the profile
// state. One word can be accepted in every cycle while stats_stall is low.
// When the receiver stalls, the result holds and the stages behind it keep
// filling; stats_stall rises only once every stage holds a word.
// Reset restores the register defaults and initial profile. Writing a thread
// or batch bound reloads the profile; the user must write the configuration
// port only while no word is in flight, which the block does not enforce.
module latency_envelope_profile_tuner #(
  parameter int unsigned TILE_MIN = lept_pkg::TILE_MIN_DEFAULT,
  parameter int unsigned TILE_MAX = lept_pkg::TILE_MAX_DEFAULT,
  parameter int unsigned PACE_MAX_NS = lept_pkg::PACE_MAX_NS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic stats_valid,
  output logic stats_stall,
  input  lept_pkg::stats_t stats,
  output logic profile_valid,
  input  logic profile_stall,
  output lept_pkg::profile_t profile,
  input  logic cfg_write,
  input  logic [lept_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lept_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam logic [20:0] PACE_CAP =
    (longint'(PACE_MAX_NS) > 64'd2097151) ? 21'h1FFFFF : 21'(PACE_MAX_NS);

  lept_pkg::cfg_t cfg;
  logic reload;
  logic env_valid;
  logic env_ready;
  lept_pkg::env_t env;

  lept_cfg u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg),
    .reload(reload)
  );

  lept_env #(
    .PACE_MAX_NS(PACE_MAX_NS)
  ) u_env (
    .clk(clk),
    .rst(rst),
    .stats_valid(stats_valid),
    .stats(stats),
    .stats_stall(stats_stall),
    .cfg(cfg),
    .env_valid(env_valid),
    .env(env),
    .env_ready(env_ready)
  );

  lept_prof #(
    .TILE_MIN(TILE_MIN),
    .TILE_MAX(TILE_MAX)
  ) u_prof (
    .clk(clk),
    .rst(rst),
    .env_valid(env_valid),
    .env(env),
    .env_ready(env_ready),
    .cfg(cfg),
    .reload(reload),
    .profile_valid(profile_valid),
    .profile(profile),
    .profile_stall(profile_stall)
  );

  a_pace_zero_inside: assert property (@(posedge clk) disable iff (rst)
    profile_valid && profile.env_ok |-> profile.pace_increment_ns == 21'd0)
    else $error("pacing increment issued inside the envelope");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    stats_stall |-> profile_valid && profile_stall && env_valid)
    else $error("input stalled while the pipeline has room");

  a_pace_bounded: assert property (@(posedge clk) disable iff (rst)
    profile_valid |-> profile.pace_increment_ns <= PACE_CAP)
    else $error("pacing increment above its saturation limit");

endmodule
